// File: sv/bms_pkg.sv
// Shared constants and codes of the buzzer melody sequencer.
package bms_pkg;

  localparam int unsigned SCORE_DEPTH_DEF    = 256;
  localparam int unsigned TIMER_CLOCK_HZ_DEF = 1000000;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned VOL_W      = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PENDING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_NOTE_COUNT   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME_SHIFT = 1'd1;

  localparam logic [WORD_W-1:0]  TONE_LOW         = 16'd20;
  localparam logic [WORD_W-1:0]  TONE_HIGH        = 16'd20000;
  localparam logic [VOL_W-1:0]   VOLUME_SHIFT_RST = 4'd6;

endpackage

// File: sv/buzzer_melody_sequencer_core.sv
// Top level of the buzzer melody sequencer: score store, tick sequencer and serial divider.
//
// The input channel takes one word per request: a score entry write, a start
// request or a time tick. Writes and starts give no result.
// Each tick gives exactly one result word on the output channel.
// A tick that does not move to a new note, that ends the score or that arrives
// while stopped goes straight to the emit state; a tick that moves to a rest
// passes the read and check states first. A tick that moves to an audible note
// reads the score store, checks the tone, then runs a restoring divider that
// produces one quotient bit per cycle over a clog2(TIMER_CLOCK_HZ+1)-bit
// dividend (20 bits at the default clock), loads the period, then shifts a copy
// of it right one bit per cycle, volume_shift times, to form the compare value,
// before the emit state.
// One request is processed at a time; the input is ready again once the
// result has moved into the output register, so a stalled receiver holds one
// finished word while the next request is already taken. A second result then
// waits inside the block and holds the input off until the receiver takes one.
// After reset the block is stopped, note_count is 0 and volume_shift is 6;
// the score store holds no defined contents until it is written.
module buzzer_melody_sequencer_core #(
  parameter int unsigned SCORE_DEPTH    = bms_pkg::SCORE_DEPTH_DEF,
  parameter int unsigned TIMER_CLOCK_HZ = bms_pkg::TIMER_CLOCK_HZ_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bms_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bms_pkg::REQ_W-1:0]       req_type_i,
  input  logic [bms_pkg::ADDR_W-1:0]      note_addr_i,
  input  logic [bms_pkg::WORD_W-1:0]      note_tone_i,
  input  logic [bms_pkg::WORD_W-1:0]      note_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            timer_update_o,
  output logic [bms_pkg::WORD_W-1:0]      pwm_period_o,
  output logic [bms_pkg::WORD_W-1:0]      pwm_compare_o,
  output logic                            is_silent_o,
  output logic [bms_pkg::MODE_W-1:0]      play_status_o
);
  import bms_pkg::*;

  localparam int unsigned IdxW  = (SCORE_DEPTH > 1) ? $clog2(SCORE_DEPTH) : 1;
  localparam int unsigned ClkW  = $clog2(TIMER_CLOCK_HZ + 1);
  localparam int unsigned CntW  = $clog2(ClkW + 1);
  localparam logic [ClkW-1:0] ClkConst = ClkW'(TIMER_CLOCK_HZ);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [WORD_W-1:0] score_tone_mem  [SCORE_DEPTH];
  logic [WORD_W-1:0] score_ticks_mem [SCORE_DEPTH];
  logic [WORD_W-1:0] tone_rd_q, ticks_rd_q;

  logic [2:0]         state_q, state_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [COUNT_W-1:0] play_index_q, play_index_d;
  logic [WORD_W-1:0]  elapsed_q, elapsed_d;
  logic [WORD_W-1:0]  cur_dur_q, cur_dur_d;
  logic [WORD_W-1:0]  period_hold_q, period_hold_d;
  logic [COUNT_W-1:0] note_count_q, note_count_d;
  logic [VOL_W-1:0]   volume_shift_q, volume_shift_d;

  logic               res_update_q, res_update_d;
  logic               res_silent_q, res_silent_d;
  logic [WORD_W-1:0]  res_compare_q, res_compare_d;
  logic [CntW-1:0]    step_cnt_q, step_cnt_d;
  logic [VOL_W-1:0]   shift_cnt_q, shift_cnt_d;
  logic [ClkW-1:0]    dvd_q, dvd_d;
  logic [WORD_W-1:0]  rem_q, rem_d;

  logic               out_valid_q, out_valid_d;
  logic               out_update_q, out_update_d;
  logic [WORD_W-1:0]  out_period_q, out_period_d;
  logic [WORD_W-1:0]  out_compare_q, out_compare_d;
  logic               out_silent_q, out_silent_d;
  logic [MODE_W-1:0]  out_status_q, out_status_d;

  logic               in_fire;
  logic               mem_we;
  logic [IdxW-1:0]    wr_addr, rd_addr;
  logic [WORD_W-1:0]  elapsed_inc;
  logic [COUNT_W-1:0] idx_eff;
  logic [WORD_W:0]    trial;
  logic [WORD_W-1:0]  trial_sub;
  logic               trial_ge;
  logic [WORD_W-1:0]  period_new;
  logic               out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_addr    = IdxW'(note_addr_i);
  assign rd_addr    = IdxW'(play_index_q);
  assign mem_we     = in_fire && (req_type_i == REQ_WRITE)
                      && (32'(note_addr_i) < 32'(SCORE_DEPTH));

  assign elapsed_inc = elapsed_q + 16'd1;
  assign idx_eff     = (mode_q == MODE_PENDING) ? '0 : play_index_q;

  assign trial      = {rem_q, dvd_q[ClkW-1]};
  assign trial_sub  = trial[WORD_W-1:0] - tone_rd_q;
  assign trial_ge   = (trial >= {1'b0, tone_rd_q});
  assign period_new = WORD_W'(dvd_q) - 16'd1;

  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      score_tone_mem[wr_addr]  <= note_tone_i;
      score_ticks_mem[wr_addr] <= note_ticks_i;
    end
    if (state_q == S_READ) begin
      tone_rd_q  <= score_tone_mem[rd_addr];
      ticks_rd_q <= score_ticks_mem[rd_addr];
    end
  end

  always_comb begin
    state_d        = state_q;
    mode_d         = mode_q;
    play_index_d   = play_index_q;
    elapsed_d      = elapsed_q;
    cur_dur_d      = cur_dur_q;
    period_hold_d  = period_hold_q;
    note_count_d   = note_count_q;
    volume_shift_d = volume_shift_q;
    res_update_d   = res_update_q;
    res_silent_d   = res_silent_q;
    res_compare_d  = res_compare_q;
    step_cnt_d     = step_cnt_q;
    shift_cnt_d    = shift_cnt_q;
    dvd_d          = dvd_q;
    rem_d          = rem_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_update_d   = out_update_q;
    out_period_d   = out_period_q;
    out_compare_d  = out_compare_q;
    out_silent_d   = out_silent_q;
    out_status_d   = out_status_q;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_NOTE_COUNT:   note_count_d   = cfg_data_i[COUNT_W-1:0];
        CFG_VOLUME_SHIFT: volume_shift_d = cfg_data_i[VOL_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (req_type_i)
            REQ_START: mode_d = MODE_PENDING;
            REQ_TICK: begin
              res_update_d  = 1'b0;
              res_silent_d  = 1'b0;
              res_compare_d = '0;
              state_d       = S_EMIT;
              if (mode_q == MODE_STOPPED) begin
                res_update_d = 1'b1;
                res_silent_d = 1'b1;
              end else if (elapsed_inc >= cur_dur_q) begin
                elapsed_d = '0;
                if ((idx_eff < note_count_q) && (32'(idx_eff) < 32'(SCORE_DEPTH))) begin
                  play_index_d = idx_eff;
                  mode_d       = MODE_PLAYING;
                  state_d      = S_READ;
                end else begin
                  play_index_d = '0;
                  mode_d       = MODE_STOPPED;
                end
              end else begin
                elapsed_d = elapsed_inc;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        cur_dur_d    = ticks_rd_q;
        play_index_d = play_index_q + 9'd1;
        if ((tone_rd_q < TONE_LOW) || (tone_rd_q > TONE_HIGH)) begin
          res_update_d  = 1'b1;
          res_silent_d  = 1'b1;
          res_compare_d = '0;
          state_d       = S_EMIT;
        end else begin
          rem_d      = '0;
          dvd_d      = ClkConst;
          step_cnt_d = CntW'(ClkW);
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        rem_d      = trial_ge ? trial_sub : trial[WORD_W-1:0];
        dvd_d      = {dvd_q[ClkW-2:0], trial_ge};
        step_cnt_d = step_cnt_q - CntW'(1);
        if (step_cnt_q == CntW'(1)) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        period_hold_d = period_new;
        res_compare_d = period_new;
        shift_cnt_d   = volume_shift_q;
        state_d       = S_SHIFT;
      end
      S_SHIFT: begin
        if (shift_cnt_q == '0) begin
          res_update_d = 1'b1;
          res_silent_d = 1'b0;
          state_d      = S_EMIT;
        end else begin
          res_compare_d = {1'b0, res_compare_q[WORD_W-1:1]};
          shift_cnt_d   = shift_cnt_q - VOL_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_update_d  = res_update_q;
          out_period_d  = period_hold_q;
          out_compare_d = res_compare_q;
          out_silent_d  = res_silent_q;
          out_status_d  = mode_q;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mode_q         <= MODE_STOPPED;
      play_index_q   <= '0;
      elapsed_q      <= '0;
      cur_dur_q      <= '0;
      period_hold_q  <= '0;
      note_count_q   <= '0;
      volume_shift_q <= VOLUME_SHIFT_RST;
      step_cnt_q     <= '0;
      shift_cnt_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      mode_q         <= mode_d;
      play_index_q   <= play_index_d;
      elapsed_q      <= elapsed_d;
      cur_dur_q      <= cur_dur_d;
      period_hold_q  <= period_hold_d;
      note_count_q   <= note_count_d;
      volume_shift_q <= volume_shift_d;
      step_cnt_q     <= step_cnt_d;
      shift_cnt_q    <= shift_cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_update_q  <= res_update_d;
    res_silent_q  <= res_silent_d;
    res_compare_q <= res_compare_d;
    dvd_q         <= dvd_d;
    rem_q         <= rem_d;
    out_update_q  <= out_update_d;
    out_period_q  <= out_period_d;
    out_compare_q <= out_compare_d;
    out_silent_q  <= out_silent_d;
    out_status_q  <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign timer_update_o = out_update_q;
  assign pwm_period_o   = out_period_q;
  assign pwm_compare_o  = out_compare_q;
  assign is_silent_o    = out_silent_q;
  assign play_status_o  = out_status_q;

endmodule

// File: sv/bms_checker.sv
// Port-level assertion checker for the buzzer melody sequencer, with its bind.
module bms_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic                            timer_update_o,
  input logic [bms_pkg::WORD_W-1:0]      pwm_period_o,
  input logic [bms_pkg::WORD_W-1:0]      pwm_compare_o,
  input logic                            is_silent_o,
  input logic [bms_pkg::MODE_W-1:0]      play_status_o
);
  import bms_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pwm_compare_o) && $stable(pwm_period_o)
      && $stable(play_status_o))
    else $error("Output word changed while stalled.");

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_silent_o |-> timer_update_o && (pwm_compare_o == '0))
    else $error("Silent word carries a nonzero compare or no update.");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !timer_update_o |-> (pwm_compare_o == '0) && !is_silent_o)
    else $error("Tick without update carries note data.");

  a_compare_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && timer_update_o && !is_silent_o |->
      (pwm_compare_o <= pwm_period_o) && (play_status_o == MODE_PLAYING))
    else $error("Audible compare exceeds period or mode is not playing.");

endmodule

bind buzzer_melody_sequencer_core bms_checker u_bms_checker (.*);
